/* sv/lpbf_pkg.sv */
// Package for the longest-path Bellman-Ford core.
// Holds payload structs, codes, FSM types and controller/datapath command structs.
// No dependencies.
package lpbf_pkg;

  localparam int unsigned MaxNodes   = 1024;
  localparam int unsigned MaxEdges   = 4096;
  localparam int unsigned NodeW      = 10;
  localparam int unsigned WeightW    = 32;
  localparam int unsigned GainW      = 49;
  localparam int unsigned ScoreW     = 48;
  localparam int unsigned NodeCountW = 11;

  localparam logic KindLoad = 1'b0;
  localparam logic KindRun  = 1'b1;

  localparam logic [1:0] StFinite    = 2'd0;
  localparam logic [1:0] StUnbounded = 2'd1;
  localparam logic [1:0] StUnreach   = 2'd2;
  localparam logic [1:0] StOverflow  = 2'd3;

  localparam logic signed [GainW-1:0] GainTop    = 49'sh0_FFFF_FFFF_FFFF;
  localparam logic signed [GainW-1:0] GainBottom = 49'sh1_0000_0000_0000;

  typedef struct packed {
    logic                      kind;
    logic [NodeW-1:0]          from_node;
    logic [NodeW-1:0]          to_node;
    logic signed [WeightW-1:0] weight;
  } item_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [ScoreW-1:0] score;
  } res_t;

  typedef struct packed {
    logic [NodeW-1:0]          from_node;
    logic [NodeW-1:0]          to_node;
    logic signed [WeightW-1:0] weight;
  } edge_t;

  typedef struct packed {
    logic                    reached;
    logic                    mark;
    logic signed [GainW-1:0] gain;
  } node_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CLR, S_PSTART, S_ERD, S_ENODE, S_EEVAL, S_EWR1, S_EWR2,
    S_PEND, S_CHK_RD, S_CHK_WR, S_FRD, S_FOUT
  } state_e;

  typedef enum logic [1:0] {PH_RELAX, PH_DET, PH_SPREAD} phase_e;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_RUN_OVF, OP_CLR, OP_EVAL, OP_WR1, OP_WR2, OP_CHK_WR, OP_EMIT
  } op_e;

  typedef enum logic [1:0] {SEL_EDGE, SEL_IDX, SEL_LAST} sel_e;

  typedef struct packed {
    op_e    op;
    phase_e phase;
    sel_e   sel;
    logic   e_clr;
    logic   e_inc;
    logic   i_clr;
    logic   i_inc;
    logic   pass_init;
    logic   pass_dec;
    logic   chg_clr;
  } cmd_t;

  typedef struct packed {
    logic edge_empty;
    logic edge_last;
    logic node_last;
    logic pass_zero;
    logic changed;
    logic ovf;
  } sts_t;

endpackage

/* sv/lpbf_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lpbf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* sv/lpbf_ctrl.sv */
// Controller state machine for the longest-path core.
// Depends on lpbf_pkg; drives the datapath through cmd_t and reads sts_t.
module lpbf_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          kind_i,
  input  lpbf_pkg::sts_t sts_i,
  output lpbf_pkg::cmd_t cmd_o,
  output logic          busy_o
);

  lpbf_pkg::state_e state_q, state_d;
  lpbf_pkg::phase_e phase_q, phase_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lpbf_pkg::S_IDLE;
      phase_q <= lpbf_pkg::PH_RELAX;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    case (state_q)
      lpbf_pkg::S_IDLE: begin
        if (start_i && kind_i == lpbf_pkg::KindRun && !sts_i.ovf) begin
          state_d = lpbf_pkg::S_CLR;
        end
      end
      lpbf_pkg::S_CLR: begin
        if (sts_i.node_last) begin
          state_d = lpbf_pkg::S_PSTART;
          phase_d = lpbf_pkg::PH_RELAX;
        end
      end
      lpbf_pkg::S_PSTART: begin
        if (phase_q == lpbf_pkg::PH_RELAX && sts_i.pass_zero) begin
          phase_d = lpbf_pkg::PH_DET;
        end else if (sts_i.edge_empty) begin
          state_d = lpbf_pkg::S_PEND;
        end else begin
          state_d = lpbf_pkg::S_ERD;
        end
      end
      lpbf_pkg::S_ERD:   state_d = lpbf_pkg::S_ENODE;
      lpbf_pkg::S_ENODE: state_d = lpbf_pkg::S_EEVAL;
      lpbf_pkg::S_EEVAL: state_d = lpbf_pkg::S_EWR1;
      lpbf_pkg::S_EWR1: begin
        if (phase_q == lpbf_pkg::PH_DET) begin
          state_d = lpbf_pkg::S_EWR2;
        end else begin
          state_d = sts_i.edge_last ? lpbf_pkg::S_PEND : lpbf_pkg::S_ERD;
        end
      end
      lpbf_pkg::S_EWR2: begin
        state_d = sts_i.edge_last ? lpbf_pkg::S_PEND : lpbf_pkg::S_ERD;
      end
      lpbf_pkg::S_PEND: begin
        case (phase_q)
          lpbf_pkg::PH_RELAX: state_d = lpbf_pkg::S_PSTART;
          lpbf_pkg::PH_DET:   state_d = lpbf_pkg::S_CHK_RD;
          default: state_d = sts_i.changed ? lpbf_pkg::S_PSTART : lpbf_pkg::S_FRD;
        endcase
      end
      lpbf_pkg::S_CHK_RD: state_d = lpbf_pkg::S_CHK_WR;
      lpbf_pkg::S_CHK_WR: begin
        if (sts_i.node_last) begin
          state_d = lpbf_pkg::S_PSTART;
          phase_d = lpbf_pkg::PH_SPREAD;
        end else begin
          state_d = lpbf_pkg::S_CHK_RD;
        end
      end
      lpbf_pkg::S_FRD:  state_d = lpbf_pkg::S_FOUT;
      lpbf_pkg::S_FOUT: state_d = lpbf_pkg::S_IDLE;
      default:          state_d = lpbf_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.op        = lpbf_pkg::OP_NONE;
    cmd_o.phase     = phase_q;
    cmd_o.sel       = lpbf_pkg::SEL_EDGE;
    case (state_q)
      lpbf_pkg::S_IDLE: begin
        if (start_i) begin
          if (kind_i == lpbf_pkg::KindLoad) begin
            cmd_o.op = lpbf_pkg::OP_LOAD;
          end else if (sts_i.ovf) begin
            cmd_o.op = lpbf_pkg::OP_RUN_OVF;
          end else begin
            cmd_o.i_clr     = 1'b1;
            cmd_o.pass_init = 1'b1;
          end
        end
      end
      lpbf_pkg::S_CLR: begin
        cmd_o.op    = lpbf_pkg::OP_CLR;
        cmd_o.i_inc = 1'b1;
      end
      lpbf_pkg::S_PSTART: begin
        if (!(phase_q == lpbf_pkg::PH_RELAX && sts_i.pass_zero) && !sts_i.edge_empty) begin
          cmd_o.e_clr = 1'b1;
        end
      end
      lpbf_pkg::S_EEVAL: cmd_o.op = lpbf_pkg::OP_EVAL;
      lpbf_pkg::S_EWR1: begin
        cmd_o.op    = lpbf_pkg::OP_WR1;
        cmd_o.e_inc = (phase_q != lpbf_pkg::PH_DET);
      end
      lpbf_pkg::S_EWR2: begin
        cmd_o.op    = lpbf_pkg::OP_WR2;
        cmd_o.e_inc = 1'b1;
      end
      lpbf_pkg::S_PEND: begin
        case (phase_q)
          lpbf_pkg::PH_RELAX: cmd_o.pass_dec = 1'b1;
          lpbf_pkg::PH_DET:   cmd_o.i_clr    = 1'b1;
          default:            cmd_o.chg_clr  = sts_i.changed;
        endcase
      end
      lpbf_pkg::S_CHK_RD: cmd_o.sel = lpbf_pkg::SEL_IDX;
      lpbf_pkg::S_CHK_WR: begin
        cmd_o.sel     = lpbf_pkg::SEL_IDX;
        cmd_o.op      = lpbf_pkg::OP_CHK_WR;
        cmd_o.i_inc   = 1'b1;
        cmd_o.chg_clr = sts_i.node_last;
      end
      lpbf_pkg::S_FRD: cmd_o.sel = lpbf_pkg::SEL_LAST;
      lpbf_pkg::S_FOUT: begin
        cmd_o.sel = lpbf_pkg::SEL_LAST;
        cmd_o.op  = lpbf_pkg::OP_EMIT;
      end
      default: cmd_o.op = lpbf_pkg::OP_NONE;
    endcase
  end

  assign busy_o = (state_q != lpbf_pkg::S_IDLE);

endmodule

/* sv/lpbf_dp.sv */
// Datapath of the longest-path core: edge table, node table, counters, result.
// Depends on lpbf_pkg and lpbf_ram; steered by lpbf_ctrl through cmd_t.
module lpbf_dp #(
  parameter int unsigned MAX_NODES = lpbf_pkg::MaxNodes,
  parameter int unsigned MAX_EDGES = lpbf_pkg::MaxEdges
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  lpbf_pkg::cmd_t                      cmd_i,
  input  lpbf_pkg::item_t                     item_i,
  input  logic [lpbf_pkg::NodeCountW-1:0]     node_count_i,
  output lpbf_pkg::sts_t                      sts_o,
  output lpbf_pkg::res_t                      res_o,
  output logic                                res_valid_o
);

  localparam int unsigned NCW = $clog2(MAX_NODES + 1);
  localparam int unsigned CW  = (NCW > lpbf_pkg::NodeCountW) ? NCW : lpbf_pkg::NodeCountW;
  localparam int unsigned NAW = $clog2(MAX_NODES);
  localparam int unsigned ECW = $clog2(MAX_EDGES + 1);
  localparam int unsigned EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned GW  = lpbf_pkg::GainW;

  logic [ECW-1:0] ecnt_q, e_q;
  logic           ovf_q, chg_q;
  logic [CW-1:0]  i_q, pass_q, n_eff, cfg_ext;
  logic           full;

  lpbf_pkg::edge_t edge_wd, edge_rd;
  lpbf_pkg::node_t ra, rb, node_wd;
  logic            node_we;
  logic [NAW-1:0]  node_wa, raddr_a, raddr_b;

  logic signed [GW:0]   sum;
  logic signed [GW-1:0] g_d, g_q;
  logic                 usable, go_q, spr_q;

  lpbf_pkg::res_t res_q;
  logic           res_valid_q;

  assign cfg_ext = CW'(node_count_i);
  always_comb begin
    if (cfg_ext == '0) begin
      n_eff = CW'(1);
    end else if (cfg_ext > CW'(MAX_NODES)) begin
      n_eff = CW'(MAX_NODES);
    end else begin
      n_eff = cfg_ext;
    end
  end

  assign full = (ecnt_q == ECW'(MAX_EDGES));

  assign edge_wd.from_node = item_i.from_node;
  assign edge_wd.to_node   = item_i.to_node;
  assign edge_wd.weight    = item_i.weight;

  lpbf_ram #(.WIDTH($bits(lpbf_pkg::edge_t)), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.op == lpbf_pkg::OP_LOAD && !full),
    .waddr_i (ecnt_q[EAW-1:0]),
    .wdata_i (edge_wd),
    .raddr_i (e_q[EAW-1:0]),
    .rdata_o (edge_rd)
  );

  always_comb begin
    case (cmd_i.sel)
      lpbf_pkg::SEL_IDX:  raddr_a = i_q[NAW-1:0];
      lpbf_pkg::SEL_LAST: raddr_a = NAW'(n_eff - CW'(1));
      default:            raddr_a = NAW'(edge_rd.from_node);
    endcase
  end
  assign raddr_b = NAW'(edge_rd.to_node);

  lpbf_ram #(.WIDTH($bits(lpbf_pkg::node_t)), .DEPTH(MAX_NODES)) u_node_ram_a (
    .clk_i   (clk_i),
    .we_i    (node_we),
    .waddr_i (node_wa),
    .wdata_i (node_wd),
    .raddr_i (raddr_a),
    .rdata_o (ra)
  );

  lpbf_ram #(.WIDTH($bits(lpbf_pkg::node_t)), .DEPTH(MAX_NODES)) u_node_ram_b (
    .clk_i   (clk_i),
    .we_i    (node_we),
    .waddr_i (node_wa),
    .wdata_i (node_wd),
    .raddr_i (raddr_b),
    .rdata_o (rb)
  );

  assign usable = (CW'(edge_rd.from_node) < n_eff) && (CW'(edge_rd.to_node) < n_eff);
  assign sum    = {ra.gain[GW-1], ra.gain} + (GW+1)'(edge_rd.weight);
  always_comb begin
    if (sum[GW] != sum[GW-1]) begin
      g_d = sum[GW] ? lpbf_pkg::GainBottom : lpbf_pkg::GainTop;
    end else begin
      g_d = sum[GW-1:0];
    end
  end

  always_comb begin
    node_we = 1'b0;
    node_wa = raddr_b;
    node_wd = rb;
    case (cmd_i.op)
      lpbf_pkg::OP_CLR: begin
        node_we         = 1'b1;
        node_wa         = i_q[NAW-1:0];
        node_wd.reached = (i_q == '0);
        node_wd.mark    = 1'b0;
        node_wd.gain    = '0;
      end
      lpbf_pkg::OP_WR1: begin
        case (cmd_i.phase)
          lpbf_pkg::PH_RELAX: begin
            node_we         = go_q;
            node_wd.reached = 1'b1;
            node_wd.gain    = g_q;
          end
          lpbf_pkg::PH_DET: begin
            node_we      = go_q;
            node_wa      = raddr_a;
            node_wd      = ra;
            node_wd.mark = 1'b1;
          end
          default: begin
            node_we      = spr_q;
            node_wd.mark = 1'b1;
          end
        endcase
      end
      lpbf_pkg::OP_WR2: begin
        node_we      = go_q;
        node_wd.mark = 1'b1;
      end
      lpbf_pkg::OP_CHK_WR: begin
        node_we      = ra.reached && (ra.gain == lpbf_pkg::GainTop);
        node_wa      = raddr_a;
        node_wd      = ra;
        node_wd.mark = 1'b1;
      end
      default: node_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == lpbf_pkg::OP_EVAL) begin
      g_q   <= g_d;
      go_q  <= usable && ra.reached && (!rb.reached || (g_d > rb.gain));
      spr_q <= usable && ra.mark && !rb.mark;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ecnt_q      <= '0;
      ovf_q       <= 1'b0;
      e_q         <= '0;
      i_q         <= '0;
      pass_q      <= '0;
      chg_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= 1'b0;
      if (cmd_i.op == lpbf_pkg::OP_LOAD) begin
        if (full) begin
          ovf_q <= 1'b1;
        end else begin
          ecnt_q <= ecnt_q + ECW'(1);
        end
      end
      if (cmd_i.op == lpbf_pkg::OP_RUN_OVF || cmd_i.op == lpbf_pkg::OP_EMIT) begin
        ecnt_q      <= '0;
        ovf_q       <= 1'b0;
        res_valid_q <= 1'b1;
      end
      if (cmd_i.e_clr) begin
        e_q <= '0;
      end else if (cmd_i.e_inc) begin
        e_q <= e_q + ECW'(1);
      end
      if (cmd_i.i_clr) begin
        i_q <= '0;
      end else if (cmd_i.i_inc) begin
        i_q <= i_q + CW'(1);
      end
      if (cmd_i.pass_init) begin
        pass_q <= n_eff - CW'(1);
      end else if (cmd_i.pass_dec) begin
        pass_q <= pass_q - CW'(1);
      end
      if (cmd_i.chg_clr) begin
        chg_q <= 1'b0;
      end else if (cmd_i.op == lpbf_pkg::OP_WR1 && cmd_i.phase == lpbf_pkg::PH_SPREAD
                   && spr_q) begin
        chg_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == lpbf_pkg::OP_RUN_OVF) begin
      res_q.status <= lpbf_pkg::StOverflow;
      res_q.score  <= '0;
    end else if (cmd_i.op == lpbf_pkg::OP_EMIT) begin
      if (ra.mark) begin
        res_q.status <= lpbf_pkg::StUnbounded;
        res_q.score  <= '0;
      end else if (!ra.reached) begin
        res_q.status <= lpbf_pkg::StUnreach;
        res_q.score  <= '0;
      end else begin
        res_q.status <= lpbf_pkg::StFinite;
        res_q.score  <= ra.gain[lpbf_pkg::ScoreW-1:0];
      end
    end
  end

  assign sts_o.edge_empty = (ecnt_q == '0);
  assign sts_o.edge_last  = (ECW'(e_q + ECW'(1)) == ecnt_q);
  assign sts_o.node_last  = (CW'(i_q + CW'(1)) == n_eff);
  assign sts_o.pass_zero  = (pass_q == '0);
  assign sts_o.changed    = chg_q;
  assign sts_o.ovf        = ovf_q;

  assign res_o       = res_q;
  assign res_valid_o = res_valid_q;

  a_full_load_sets_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == lpbf_pkg::OP_LOAD && full) |=> ovf_q)
    else $error("dropped load did not set the overflow flag");

  a_res_from_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> $past(cmd_i.op == lpbf_pkg::OP_EMIT || cmd_i.op == lpbf_pkg::OP_RUN_OVF))
    else $error("result strobe without a finished run");

  a_ecnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ecnt_q <= ECW'(MAX_EDGES))
    else $error("edge count beyond table size");

endmodule

/* sv/longest_path_bellman_ford_core.sv */
// Longest-path Bellman-Ford core: a load word is taken while busy is low, and a new
// one can follow every cycle. A run word clears the node records, makes n-1 relaxation
// passes over the edges, one detection pass, a check of every node and mark-spreading
// passes until no mark changes; the edge loop reads each edge, then the node RAMs. An
// overflowed run returns its word in the next cycle. Reset is asynchronous, active low:
// the edge table is empty and node_count is 1; node records are set up at each run.
module longest_path_bellman_ford_core #(
  parameter int unsigned MAX_NODES = lpbf_pkg::MaxNodes,
  parameter int unsigned MAX_EDGES = lpbf_pkg::MaxEdges
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  lpbf_pkg::item_t item_i,
  output logic            res_valid_o,
  output lpbf_pkg::res_t  res_o,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [1:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);

  logic [lpbf_pkg::NodeCountW-1:0] node_count_q;
  lpbf_pkg::cmd_t cmd;
  lpbf_pkg::sts_t sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= lpbf_pkg::NodeCountW'(1);
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      node_count_q <= pwdata[lpbf_pkg::NodeCountW-1:0];
    end
  end

  assign prdata = 32'(node_count_q);
  assign pready = 1'b1;

  lpbf_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .kind_i  (item_i.kind),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  lpbf_dp #(.MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES)) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .item_i       (item_i),
    .node_count_i (node_count_q),
    .sts_o        (sts),
    .res_o        (res_o),
    .res_valid_o  (res_valid_o)
  );

endmodule

/* dv/longest_path_bellman_ford_core_checker.sv */
// Checker for the longest-path Bellman-Ford core: watches the command, result and
// register ports, predicts each search result and compares it field by field.
// Depends on lpbf_pkg for the payload structs and status codes.
module longest_path_bellman_ford_core_checker (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  input  logic            busy,
  input  lpbf_pkg::item_t item_i,
  input  logic            res_valid_o,
  input  lpbf_pkg::res_t  res_o,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [1:0]      paddr,
  input  logic [31:0]     pwdata,
  input  logic            pready,
  output int              fail_count_o,
  output int              pending_o,
  output int              load_count_o,
  output int              search_count_o,
  output int              status_count_o [4]
);
  timeunit 1ns;
  timeprecision 1ps;
  import lpbf_pkg::*;

  localparam longint GainHi = 64'sh0000_FFFF_FFFF_FFFF;
  localparam longint GainLo = -64'sh0001_0000_0000_0000;

  logic [NodeW-1:0] edge_src [MaxEdges];
  logic [NodeW-1:0] edge_dst [MaxEdges];
  int               edge_gain [MaxEdges];
  int unsigned      edge_total;
  bit               table_ovf;
  logic [NodeCountW-1:0] node_cfg;

  longint node_gain [MaxNodes];
  bit     node_seen [MaxNodes];
  bit     node_mark [MaxNodes];

  res_t expected_words [$];

  function automatic longint clamp_gain(longint g);
    if (g > GainHi) return GainHi;
    if (g < GainLo) return GainLo;
    return g;
  endfunction

  function automatic res_t search_result();
    int unsigned n;
    int unsigned a;
    int unsigned b;
    longint g;
    bit changed;
    res_t r;
    n = (node_cfg == 0) ? 1 : (node_cfg > MaxNodes) ? MaxNodes : node_cfg;
    r = '0;
    if (table_ovf) begin
      r.status = StOverflow;
      return r;
    end
    for (int i = 0; i < MaxNodes; i++) begin
      node_gain[i] = 0;
      node_seen[i] = 0;
      node_mark[i] = 0;
    end
    node_seen[0] = 1;
    for (int p = 1; p < n; p++) begin
      for (int e = 0; e < edge_total; e++) begin
        a = edge_src[e];
        b = edge_dst[e];
        if (a < n && b < n && node_seen[a]) begin
          g = clamp_gain(node_gain[a] + longint'(edge_gain[e]));
          if (!node_seen[b] || g > node_gain[b]) begin
            node_gain[b] = g;
            node_seen[b] = 1;
          end
        end
      end
    end
    for (int e = 0; e < edge_total; e++) begin
      a = edge_src[e];
      b = edge_dst[e];
      if (a < n && b < n && node_seen[a]) begin
        g = clamp_gain(node_gain[a] + longint'(edge_gain[e]));
        if (!node_seen[b] || g > node_gain[b]) begin
          node_mark[a] = 1;
          node_mark[b] = 1;
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      if (node_seen[i] && node_gain[i] == GainHi) node_mark[i] = 1;
    end
    do begin
      changed = 0;
      for (int e = 0; e < edge_total; e++) begin
        a = edge_src[e];
        b = edge_dst[e];
        if (a < n && b < n && node_mark[a] && !node_mark[b]) begin
          node_mark[b] = 1;
          changed = 1;
        end
      end
    end while (changed);
    if (node_mark[n-1]) begin
      r.status = StUnbounded;
    end else if (!node_seen[n-1]) begin
      r.status = StUnreach;
    end else begin
      r.status = StFinite;
      r.score  = node_gain[n-1][ScoreW-1:0];
    end
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    int   errs;
    if (!rst_ni) begin
      edge_total     <= 0;
      table_ovf      <= 0;
      node_cfg       <= 1;
      fail_count_o   <= 0;
      load_count_o   <= 0;
      search_count_o <= 0;
      for (int i = 0; i < 4; i++) status_count_o[i] <= 0;
      expected_words.delete();
    end else begin
      errs = 0;
      if (psel && penable && pwrite && pready && paddr == '0) begin
        node_cfg <= pwdata[NodeCountW-1:0];
      end
      if (start && !busy) begin
        if (item_i.kind == KindLoad) begin
          load_count_o <= load_count_o + 1;
          if (edge_total >= MaxEdges) begin
            table_ovf <= 1;
          end else begin
            edge_src[edge_total]  = item_i.from_node;
            edge_dst[edge_total]  = item_i.to_node;
            edge_gain[edge_total] = item_i.weight;
            edge_total <= edge_total + 1;
          end
        end else begin
          want = search_result();
          expected_words.push_back(want);
          search_count_o <= search_count_o + 1;
          status_count_o[want.status] <= status_count_o[want.status] + 1;
          edge_total <= 0;
          table_ovf  <= 0;
        end
      end
      if (res_valid_o) begin
        if (expected_words.size() == 0) begin
          $error("result word with no search pending: status %0d score %0d",
                 res_o.status, res_o.score);
          errs = errs + 1;
        end else begin
          want = expected_words.pop_front();
          if (res_o.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, res_o.status);
            errs = errs + 1;
          end
          if (res_o.score !== want.score) begin
            $error("score: expected %0d, actual %0d", want.score, res_o.score);
            errs = errs + 1;
          end
        end
      end
      if (errs != 0) begin
        fail_count_o <= fail_count_o + errs;
      end
    end
  end

  assign pending_o = expected_words.size();

endmodule

/* dv/longest_path_bellman_ford_core_test.sv */
// Testbench top for the longest-path Bellman-Ford core: drives edge loads, searches
// and node_count writes with random gaps, and gives the verdict from the checker.
// Depends on lpbf_pkg, longest_path_bellman_ford_core and its checker module.
module longest_path_bellman_ford_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import lpbf_pkg::*;

  localparam int StallLimit = 600000;
  localparam int RandomItems = 1550;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        start = 0;
  logic        busy;
  item_t       item_i = '0;
  logic        res_valid_o;
  res_t        res_o;
  logic        psel = 0;
  logic        penable = 0;
  logic        pwrite = 0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int fail_count;
  int pending;
  int load_count;
  int search_count;
  int status_count [4];
  int idle_pct;
  int sent;
  int quiet_cycles;
  int unsigned cur_nodes;

  always begin
    #2 clk_i = 1;
    #2 clk_i = 0;
  end

  longest_path_bellman_ford_core u_top (.*);

  longest_path_bellman_ford_core_checker u_check (
    .clk_i, .rst_ni, .start, .busy, .item_i, .res_valid_o, .res_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fail_count_o(fail_count), .pending_o(pending), .load_count_o(load_count),
    .search_count_o(search_count), .status_count_o(status_count)
  );

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || res_valid_o || psel) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("** longest_path_bellman_ford_core: FAILED **");
      $finish;
    end
  end

  task automatic send_word(item_t w);
    start  <= 1;
    item_i <= w;
    do @(posedge clk_i); while (busy);
    sent++;
    if ($urandom_range(99) < idle_pct) begin
      start <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic load_edge(int unsigned a, int unsigned b, logic [31:0] w);
    item_t it;
    it.kind      = KindLoad;
    it.from_node = a[NodeW-1:0];
    it.to_node   = b[NodeW-1:0];
    it.weight    = w;
    send_word(it);
  endtask

  task automatic run_search();
    item_t it;
    it = {KindRun, 52'($urandom()) ^ {20'($urandom()), 32'($urandom())}};
    send_word(it);
  endtask

  task automatic set_nodes(logic [31:0] v);
    start <= 0;
    @(posedge clk_i);
    while (pending != 0 || busy) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    psel    <= 1;
    pwrite  <= 1;
    paddr   <= '0;
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel    <= 0;
    penable <= 0;
    pwrite  <= 0;
    @(posedge clk_i);
    cur_nodes = (v[10:0] == 0) ? 1 : (v[10:0] > MaxNodes) ? MaxNodes : v[10:0];
  endtask

  function automatic logic [31:0] pick_weight();
    case ($urandom_range(5))
      0: return 32'($signed($urandom_range(40)) - 20);
      1: return 32'($urandom_range(100));
      2: return 32'h7FFF_FFFF;
      3: return 32'h8000_0000;
      4: return 32'(-$signed($urandom_range(1000)));
      default: return $urandom();
    endcase
  endfunction

  function automatic int unsigned pick_node();
    if ($urandom_range(9) == 0) return $urandom_range(1023);
    return $urandom_range(cur_nodes - 1);
  endfunction

  task automatic random_part(int count);
    int edges;
    int last;
    last = sent + count;
    while (sent < last) begin
      if ($urandom_range(24) == 0) begin
        case ($urandom_range(9))
          0: set_nodes(0);
          1: set_nodes(1);
          2: set_nodes(1024);
          3: set_nodes({$urandom_range(2047, 1025)} | 32'hFFFF_F800);
          default: set_nodes($urandom_range(2, 12));
        endcase
      end
      edges = (cur_nodes > 16) ? $urandom_range(3) : $urandom_range(8);
      if ($urandom_range(9) == 0) begin
        for (int i = 0; i < edges; i++) load_edge(pick_node(), pick_node(), pick_weight());
      end else begin
        for (int i = 0; i < edges; i++) begin
          load_edge(i % cur_nodes, (i + 1) % cur_nodes, pick_weight());
          if ($urandom_range(2) == 0) load_edge(pick_node(), pick_node(), pick_weight());
        end
      end
      run_search();
    end
  endtask

  initial begin
    sent = 0;
    cur_nodes = 1;
    idle_pct = 32;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    run_search();
    load_edge(0, 0, 32'h0000_0005);
    run_search();
    set_nodes(0);
    load_edge(0, 0, 32'hFFFF_FFFF);
    run_search();
    set_nodes(2047);
    load_edge(0, 1023, 32'h7FFF_FFFF);
    run_search();
    set_nodes(1024);
    load_edge(0, 1023, 32'h8000_0000);
    load_edge(1023, 0, 32'h7FFF_FFFF);
    run_search();
    set_nodes(3);
    load_edge(0, 1, 32'd7);
    run_search();
    load_edge(0, 1, 32'd3);
    load_edge(1, 2, 32'd4);
    load_edge(0, 2, 32'd6);
    load_edge(0, 1000, 32'd9);
    load_edge(1000, 2, 32'd9);
    run_search();
    load_edge(0, 1, 32'd2);
    load_edge(1, 0, 32'hFFFF_FFFF);
    load_edge(1, 0, 32'd1);
    load_edge(1, 2, 32'd1);
    run_search();
    set_nodes(4);
    for (int i = 0; i <= MaxEdges; i++) load_edge(i % 4, (i + 1) % 4, pick_weight());
    run_search();
    for (int i = 0; i < MaxEdges; i++) load_edge(i % 4, (i + 1) % 4, 32'hFFFF_FFF0);
    run_search();
    run_search();

    sent = 0;
    random_part(RandomItems / 3);
    idle_pct = 65;
    random_part(RandomItems / 3);
    idle_pct = 0;
    random_part(RandomItems / 3);

    start <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("Covered %0d edge loads and %0d searches: %0d finite, %0d unbounded,",
             load_count, search_count, status_count[0], status_count[1]);
    $display("%0d unreachable and %0d overflowed.", status_count[2], status_count[3]);
    if (fail_count == 0 && pending == 0) begin
      $display("** longest_path_bellman_ford_core: PASSED **");
    end else begin
      $display("** longest_path_bellman_ford_core: FAILED **");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/lpbf_pkg.sv
sv/lpbf_ram.sv
sv/lpbf_ctrl.sv
sv/lpbf_dp.sv
sv/longest_path_bellman_ford_core.sv
dv/longest_path_bellman_ford_core_checker.sv
dv/longest_path_bellman_ford_core_test.sv
